// ----- rtl/bef_pkg.sv -----
// ----------------------------------------------------------------------------
// bef_pkg: shared types, constants and table builders
// Codes, control structs and elaboration-time helpers for the belief fusion
// block.
// ----------------------------------------------------------------------------
package bef_pkg;

  localparam int HARMONIC_MAX_DEF    = 8;
  localparam int SNR_TABLE_DEPTH_DEF = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PRIOR      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HARM_LIMIT = 3'd5;

  localparam logic [31:0] PRIOR_RST      = 32'd42949673;
  localparam logic [15:0] DECAY_RATE_RST = 16'd62259;
  localparam logic [15:0] MIN_FREQ_RST   = 16'd50;
  localparam logic [15:0] MAX_FREQ_RST   = 16'd2000;
  localparam logic [15:0] TOLERANCE_RST  = 16'd3277;
  localparam logic [3:0]  HARM_LIMIT_RST = 4'd4;

  // Likelihoods, unsigned 8.24
  localparam logic [31:0] L_VIS_OUT_D  = 32'd1677722;
  localparam logic [31:0] L_VIS_OUT_ND = 32'd5033165;
  localparam logic [31:0] L_AC_OUT_D   = 32'd838861;
  localparam logic [31:0] L_AC_OUT_ND  = 32'd3355443;
  localparam logic [31:0] L_AC_ND      = 32'd838861;
  localparam logic [31:0] L_AC_ND_HIGH = 32'd83886;
  localparam logic [31:0] L_MATCH_D    = 32'd16609444;
  localparam logic [31:0] L_MATCH_ND   = 32'd16777;

  localparam logic [31:0] P_MIN = 32'd4;
  localparam logic [31:0] P_MAX = 32'hFFFF_FFFC;

  // snr offsets in 8.8: 5 dB and 4 dB; elevation limit 10 degrees
  localparam logic signed [16:0] VIS_SNR_OFS = 17'sd1280;
  localparam logic signed [16:0] AC_SNR_OFS  = 17'sd1024;
  localparam logic signed [15:0] ELEV_HIGH   = 16'sd2560;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef enum logic [1:0] {
    LSEL_VIS,
    LSEL_AC,
    LSEL_MATCH
  } lsel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_LIK,
    S_MUL_A,
    S_MUL_B,
    S_DIV_INIT,
    S_DIV,
    S_SRCH_INIT,
    S_SRCH,
    S_CLAMP,
    S_DEC_A,
    S_DEC_B,
    S_DONE
  } state_t;

  typedef struct packed {
    logic  capture;
    logic  load_lik;
    lsel_t lsel;
    logic  mul_a;
    logic  mul_b;
    logic  div_init;
    logic  div_step;
    logic  srch_init;
    logic  srch_step;
    logic  clamp;
    logic  dec_a;
    logic  dec_b;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic req_decay;
    logic vis;
    logic ac;
    logic div_skip;
    logic div_last;
    logic srch_none;
    logic srch_last;
    logic srch_hit;
  } sts_t;

  // Shift-subtract divide, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] mulq30(input logic [63:0] a, input logic [63:0] b);
    logic [128:0] s;
    s = 129'(a) * 129'(b) + (129'(1) << 29);
    if (s[128:94] != '0) begin
      return '1;
    end
    return s[93:30];
  endfunction

  // exp(+u) or exp(-u), u in Q30, result in Q30
  function automatic logic [63:0] exp_q30(input logic [63:0] u, input logic neg);
    logic [63:0]  w;
    logic [63:0]  term;
    logic [63:0]  pos;
    logic [63:0]  sub;
    logic [63:0]  r;
    logic [127:0] t;
    w    = (u + 64'd16) >> 5;
    term = ONE_Q30;
    pos  = ONE_Q30;
    sub  = '0;
    for (int k = 1; k <= 14; k++) begin
      t    = 128'(term) * 128'(w);
      term = udiv64(64'(t >> 30), 64'(k));
      if (neg && (k % 2 == 1)) begin
        sub = sub + term;
      end else begin
        pos = pos + term;
      end
    end
    r = pos - sub;
    for (int i = 0; i < 5; i++) begin
      r = mulq30(r, r);
    end
    return r;
  endfunction

  // {logistic, non-drone} entry k of a table of the given depth
  function automatic logic [63:0] snr_entry(input int k, input int depth);
    logic [63:0] num;
    logic [63:0] c;
    logic        nonneg;
    logic [63:0] mag;
    logic [63:0] u;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] s;
    logic [63:0] v;
    logic [31:0] lg;
    num    = 64'(64 * k);
    c      = 64'(32 * depth);
    nonneg = num >= c;
    mag    = nonneg ? num - c : c - num;
    u      = udiv64(mag << 30, 64'(depth));
    e      = exp_q30(u, 1'b1);
    den    = ONE_Q30 + e;
    if (nonneg) begin
      s = udiv64((64'd1 << 60) + (den >> 1), den);
    end else begin
      s = udiv64((e << 30) + (den >> 1), den);
    end
    lg = 32'((s + 64'd32) >> 6);
    e  = exp_q30((u + 64'd1) >> 1, nonneg);
    v  = udiv64(e + 64'd3200, 64'd6400);
    if (v > 64'hFFFF_FFFF) begin
      v = 64'hFFFF_FFFF;
    end
    if (v == '0) begin
      v = 64'd1;
    end
    return {lg, v[31:0]};
  endfunction

endpackage

// ----- rtl/bef_ctrl.sv -----
// ----------------------------------------------------------------------------
// bef_ctrl: sequencing state machine
// Walks each item through its Bayes steps, the harmonic search, clamp or
// decay, and owns both handshakes.
// ----------------------------------------------------------------------------
module bef_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  bef_pkg::sts_t sts,
  output bef_pkg::cmd_t cmd
);

  bef_pkg::state_t state_r, state_nxt;
  bef_pkg::lsel_t  stp_r, stp_nxt;
  logic            out_valid_r, out_valid_nxt;
  bef_pkg::state_t after_state;
  bef_pkg::lsel_t  after_stp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bef_pkg::S_IDLE;
      stp_r       <= bef_pkg::LSEL_VIS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stp_r       <= stp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // where to go once a Bayes step has finished
  always_comb begin
    after_state = bef_pkg::S_CLAMP;
    after_stp   = stp_r;
    case (stp_r)
      bef_pkg::LSEL_VIS: begin
        if (sts.ac) begin
          after_state = bef_pkg::S_LIK;
          after_stp   = bef_pkg::LSEL_AC;
        end
      end
      bef_pkg::LSEL_AC: begin
        if (sts.vis) begin
          after_state = bef_pkg::S_SRCH_INIT;
        end
      end
      default: after_state = bef_pkg::S_CLAMP;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.lsel      = stp_r;
    state_nxt     = state_r;
    stp_nxt       = stp_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      bef_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = bef_pkg::S_START;
        end
      end
      bef_pkg::S_START: begin
        if (sts.req_decay) begin
          state_nxt = bef_pkg::S_DEC_A;
        end else if (sts.vis) begin
          stp_nxt   = bef_pkg::LSEL_VIS;
          state_nxt = bef_pkg::S_LIK;
        end else if (sts.ac) begin
          stp_nxt   = bef_pkg::LSEL_AC;
          state_nxt = bef_pkg::S_LIK;
        end else begin
          state_nxt = bef_pkg::S_CLAMP;
        end
      end
      bef_pkg::S_LIK: begin
        cmd.load_lik = 1'b1;
        state_nxt    = bef_pkg::S_MUL_A;
      end
      bef_pkg::S_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_nxt = bef_pkg::S_MUL_B;
      end
      bef_pkg::S_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_nxt = bef_pkg::S_DIV_INIT;
      end
      bef_pkg::S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        if (sts.div_skip) begin
          state_nxt = after_state;
          stp_nxt   = after_stp;
        end else begin
          state_nxt = bef_pkg::S_DIV;
        end
      end
      bef_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = after_state;
          stp_nxt   = after_stp;
        end
      end
      bef_pkg::S_SRCH_INIT: begin
        cmd.srch_init = 1'b1;
        state_nxt     = sts.srch_none ? bef_pkg::S_CLAMP : bef_pkg::S_SRCH;
      end
      bef_pkg::S_SRCH: begin
        cmd.srch_step = 1'b1;
        if (sts.srch_last) begin
          if (sts.srch_hit) begin
            stp_nxt   = bef_pkg::LSEL_MATCH;
            state_nxt = bef_pkg::S_LIK;
          end else begin
            state_nxt = bef_pkg::S_CLAMP;
          end
        end
      end
      bef_pkg::S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = bef_pkg::S_DONE;
      end
      bef_pkg::S_DEC_A: begin
        cmd.dec_a = 1'b1;
        state_nxt = bef_pkg::S_DEC_B;
      end
      bef_pkg::S_DEC_B: begin
        cmd.dec_b = 1'b1;
        state_nxt = bef_pkg::S_DONE;
      end
      bef_pkg::S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bef_pkg::S_IDLE;
        end
      end
      default: state_nxt = bef_pkg::S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != bef_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result loaded over an undelivered beat");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == bef_pkg::S_START))
    else $error("accepted beat not started");

  a_match_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bef_pkg::S_LIK && stp_r == bef_pkg::LSEL_MATCH) |->
      $past(state_r) == bef_pkg::S_SRCH)
    else $error("match step without search hit");

endmodule

// ----- rtl/bef_dp.sv -----
// ----------------------------------------------------------------------------
// bef_dp: probability datapath
// Config registers, captured item, likelihood tables, multipliers and
// 32-step divider for the Bayes steps, harmonic search and decay blend.
// ----------------------------------------------------------------------------
module bef_dp #(
  parameter int HARMONIC_MAX    = bef_pkg::HARMONIC_MAX_DEF,
  parameter int SNR_TABLE_DEPTH = bef_pkg::SNR_TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bef_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_req_type,
  input  logic                           in_visual_valid,
  input  logic signed [15:0]             in_visual_snr,
  input  logic [15:0]                    in_visual_freq,
  input  logic                           in_acoustic_valid,
  input  logic signed [15:0]             in_acoustic_snr,
  input  logic [15:0]                    in_acoustic_freq,
  input  logic                           in_elevation_valid,
  input  logic signed [15:0]             in_elevation,
  input  bef_pkg::cmd_t                  cmd,
  output bef_pkg::sts_t                  sts,
  output logic [31:0]                    out_probability,
  output logic                           out_matched,
  output logic [3:0]                     out_harmonic_visual,
  output logic [3:0]                     out_harmonic_acoustic
);

  localparam int IW     = $clog2(SNR_TABLE_DEPTH);
  localparam int PW     = 17 + $clog2(SNR_TABLE_DEPTH + 1);
  localparam int LW     = $clog2(HARMONIC_MAX + 1);
  localparam int MT_DEP = HARMONIC_MAX * HARMONIC_MAX + 1;
  localparam int MIW    = $clog2(MT_DEP);
  localparam int XW     = 16 + LW;
  localparam int CW     = 32 + LW;

  typedef logic [31:0] rom_t [SNR_TABLE_DEPTH];
  typedef logic [31:0] mtab_t [MT_DEP];

  function automatic rom_t build_rom(input logic sel_nd);
    rom_t        t;
    logic [63:0] e;
    for (int k = 0; k < SNR_TABLE_DEPTH; k++) begin
      e    = bef_pkg::snr_entry(k, SNR_TABLE_DEPTH);
      t[k] = sel_nd ? e[31:0] : e[63:32];
    end
    return t;
  endfunction

  function automatic mtab_t build_mtab();
    mtab_t t;
    for (int n = 0; n < MT_DEP; n++) begin
      if (n == 0) begin
        t[n] = '0;
      end else begin
        t[n] = 32'(bef_pkg::udiv64(64'(bef_pkg::L_MATCH_D) + 64'(n / 2), 64'(n)));
      end
    end
    return t;
  endfunction

  localparam rom_t  LOGI_ROM  = build_rom(1'b0);
  localparam rom_t  ND_ROM    = build_rom(1'b1);
  localparam mtab_t MATCH_TAB = build_mtab();

  function automatic logic [IW-1:0] rom_idx(input logic signed [16:0] v);
    logic signed [17:0] t;
    logic [PW-1:0]      prod;
    logic [PW-1:0]      idx;
    t    = 18'(v) + 18'sd8192;
    prod = PW'(t[16:0]) * PW'(SNR_TABLE_DEPTH);
    idx  = prod >> 14;
    if (t < 0) begin
      return '0;
    end
    if (idx >= PW'(SNR_TABLE_DEPTH)) begin
      return IW'(SNR_TABLE_DEPTH - 1);
    end
    return idx[IW-1:0];
  endfunction

  // configuration
  logic [31:0] prior_r;
  logic [15:0] decay_r, minf_r, maxf_r, tol_r;
  logic [3:0]  hlim_r;

  // captured item
  logic               req_r, vis_r, ac_r, elv_r;
  logic signed [15:0] vsnr_r, asnr_r, elev_r;
  logic [15:0]        vf_r, af_r;

  // working state
  logic [31:0]   p_r;
  logic [31:0]   ld_r, lnd_r;
  logic [63:0]   a_r, b_r;
  logic [63:0]   rem_r, den_r;
  logic [31:0]   q_r;
  logic [4:0]    cnt_r;
  logic [LW-1:0] nv_r, na_r, hv_r, ha_r;
  logic [31:0]   tf_r;

  logic [31:0] out_prob_r;
  logic        out_match_r;
  logic [3:0]  out_hv_r, out_ha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r <= bef_pkg::PRIOR_RST;
      decay_r <= bef_pkg::DECAY_RATE_RST;
      minf_r  <= bef_pkg::MIN_FREQ_RST;
      maxf_r  <= bef_pkg::MAX_FREQ_RST;
      tol_r   <= bef_pkg::TOLERANCE_RST;
      hlim_r  <= bef_pkg::HARM_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bef_pkg::CFG_PRIOR:      prior_r <= cfg_data;
        bef_pkg::CFG_DECAY_RATE: decay_r <= cfg_data[15:0];
        bef_pkg::CFG_MIN_FREQ:   minf_r  <= cfg_data[15:0];
        bef_pkg::CFG_MAX_FREQ:   maxf_r  <= cfg_data[15:0];
        bef_pkg::CFG_TOLERANCE:  tol_r   <= cfg_data[15:0];
        bef_pkg::CFG_HARM_LIMIT: hlim_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // combinational helpers
  logic          vis_inb, ac_inb, elev_high;
  logic [IW-1:0] idx_vd, idx_vnd, idx_ad, idx_d;
  logic [LW-1:0] lim;
  logic [MIW-1:0] mt_idx;
  logic [32:0]   omp;
  logic [64:0]   prod_b;
  logic [63:0]   den_w;
  logic [64:0]   r2;
  logic          ge;
  logic [31:0]   q_nxt;
  logic [XW-1:0] xv, ya, diff;
  logic [CW-1:0] lhs, rhs;
  logic          hit;
  logic [48:0]   blend;

  always_comb begin
    vis_inb   = (vf_r >= minf_r) && (vf_r <= maxf_r);
    ac_inb    = (af_r >= minf_r) && (af_r <= maxf_r);
    elev_high = elv_r && (elev_r > bef_pkg::ELEV_HIGH);
    idx_vd    = rom_idx(17'(vsnr_r) - bef_pkg::VIS_SNR_OFS);
    idx_vnd   = rom_idx(17'(vsnr_r));
    idx_ad    = rom_idx(17'(asnr_r) - bef_pkg::AC_SNR_OFS);
    idx_d     = (cmd.lsel == bef_pkg::LSEL_VIS) ? idx_vd : idx_ad;
    lim       = (32'(hlim_r) < HARMONIC_MAX) ? LW'(hlim_r) : LW'(HARMONIC_MAX);
    mt_idx    = MIW'(hv_r) * MIW'(ha_r);
    omp       = 33'h1_0000_0000 - {1'b0, p_r};
    prod_b    = 65'(lnd_r) * 65'(omp);
    den_w     = a_r + b_r;
    r2        = {rem_r, 1'b0};
    ge        = r2 >= {1'b0, den_r};
    q_nxt     = {q_r[30:0], ge};
    xv        = XW'(vf_r) * XW'(na_r);
    ya        = XW'(af_r) * XW'(nv_r);
    diff      = (xv > ya) ? xv - ya : ya - xv;
    lhs       = CW'(diff) << 16;
    rhs       = CW'(tf_r) * CW'(nv_r);
    hit       = (lhs < rhs) || (af_r == '0 && vf_r == '0 && tol_r != '0);
    blend     = 49'(a_r[47:0]) + 49'(17'h1_0000 - 17'(decay_r)) * 49'(prior_r)
                + 49'd32768;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= bef_pkg::PRIOR_RST;
    end else begin
      if (cmd.div_init) begin
        if (b_r == '0 && den_w != '0) begin
          p_r <= 32'hFFFF_FFFF;
        end
      end
      if (cmd.div_step && cnt_r == 5'd31) begin
        p_r <= q_nxt;
      end
      if (cmd.clamp) begin
        if (p_r < bef_pkg::P_MIN) begin
          p_r <= bef_pkg::P_MIN;
        end else if (p_r > bef_pkg::P_MAX) begin
          p_r <= bef_pkg::P_MAX;
        end
      end
      if (cmd.dec_b) begin
        p_r <= blend[47:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req_type;
      vis_r  <= in_visual_valid;
      vsnr_r <= in_visual_snr;
      vf_r   <= in_visual_freq;
      ac_r   <= in_acoustic_valid;
      asnr_r <= in_acoustic_snr;
      af_r   <= in_acoustic_freq;
      elv_r  <= in_elevation_valid;
      elev_r <= in_elevation;
      hv_r   <= '0;
      ha_r   <= '0;
    end
    if (cmd.load_lik) begin
      case (cmd.lsel)
        bef_pkg::LSEL_VIS: begin
          ld_r  <= vis_inb ? LOGI_ROM[idx_d] : bef_pkg::L_VIS_OUT_D;
          lnd_r <= vis_inb ? ND_ROM[idx_vnd] : bef_pkg::L_VIS_OUT_ND;
        end
        bef_pkg::LSEL_AC: begin
          ld_r  <= ac_inb ? LOGI_ROM[idx_d] : bef_pkg::L_AC_OUT_D;
          lnd_r <= !ac_inb ? bef_pkg::L_AC_OUT_ND :
                   elev_high ? bef_pkg::L_AC_ND_HIGH : bef_pkg::L_AC_ND;
        end
        default: begin
          ld_r  <= MATCH_TAB[mt_idx];
          lnd_r <= bef_pkg::L_MATCH_ND;
        end
      endcase
    end
    if (cmd.mul_a) begin
      a_r <= (64'(ld_r) * 64'(p_r)) >> 1;
    end
    if (cmd.dec_a) begin
      a_r <= 64'(48'(decay_r) * 48'(p_r));
    end
    if (cmd.mul_b) begin
      b_r <= prod_b[64:1];
    end
    if (cmd.div_init) begin
      rem_r <= a_r;
      den_r <= den_w;
      q_r   <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? 64'(r2 - {1'b0, den_r}) : r2[63:0];
      q_r   <= q_nxt;
      cnt_r <= cnt_r + 5'd1;
    end
    if (cmd.srch_init) begin
      nv_r <= LW'(1);
      na_r <= LW'(1);
      tf_r <= 32'(tol_r) * 32'(af_r);
    end
    if (cmd.srch_step) begin
      if (hit) begin
        hv_r <= nv_r;
        ha_r <= na_r;
      end else if (na_r == lim) begin
        nv_r <= nv_r + LW'(1);
        na_r <= LW'(1);
      end else begin
        na_r <= na_r + LW'(1);
      end
    end
    if (cmd.out_load) begin
      out_prob_r  <= p_r;
      out_match_r <= hv_r != '0;
      out_hv_r    <= 4'(hv_r);
      out_ha_r    <= 4'(ha_r);
    end
  end

  always_comb begin
    sts.req_decay = req_r;
    sts.vis       = vis_r;
    sts.ac        = ac_r;
    sts.div_skip  = (den_w == '0) || (b_r == '0);
    sts.div_last  = cnt_r == 5'd31;
    sts.srch_none = lim == '0;
    sts.srch_hit  = hit;
    sts.srch_last = hit || (na_r == lim && nv_r == lim);
  end

  assign out_probability       = out_prob_r;
  assign out_matched           = out_match_r;
  assign out_harmonic_visual   = out_hv_r;
  assign out_harmonic_acoustic = out_ha_r;

  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clamp |=> (p_r >= bef_pkg::P_MIN && p_r <= bef_pkg::P_MAX))
    else $error("probability outside clamp range");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.srch_step |-> (nv_r != '0 && na_r != '0 && nv_r <= lim && na_r <= lim))
    else $error("harmonic counters out of range");

endmodule

// ----- rtl/bayesian_evidence_fusion.sv -----
// ----------------------------------------------------------------------------
// bayesian_evidence_fusion: drone belief from visual and acoustic evidence
// Holds one drone probability (0.32) and updates it per request by Bayes
// steps with table-driven likelihoods, a harmonic match, clamp or decay.
// ----------------------------------------------------------------------------
// One item at a time. A decay tick runs the two decay states, then loads the
// result. An evidence update runs a Bayes step per kind of evidence present
// (table load, two multiplies, divider setup and a restoring divider that
// yields one quotient bit a cycle; the divide is skipped when its divisor
// or the non-drone product is zero), then the harmonic search when both
// kinds of evidence are present, which tries at most L*L harmonic pairs
// with L = min(harmonic_limit, HARMONIC_MAX); with a match a third Bayes
// step follows. The next item is taken as soon as the result sits in the
// output register, even while it is still stalled.
module bayesian_evidence_fusion #(
  parameter int HARMONIC_MAX    = bef_pkg::HARMONIC_MAX_DEF,
  parameter int SNR_TABLE_DEPTH = bef_pkg::SNR_TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bef_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_req_type,
  input  logic                           in_visual_valid,
  input  logic signed [15:0]             in_visual_snr,
  input  logic [15:0]                    in_visual_freq,
  input  logic                           in_acoustic_valid,
  input  logic signed [15:0]             in_acoustic_snr,
  input  logic [15:0]                    in_acoustic_freq,
  input  logic                           in_elevation_valid,
  input  logic signed [15:0]             in_elevation,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_probability,
  output logic                           out_matched,
  output logic [3:0]                     out_harmonic_visual,
  output logic [3:0]                     out_harmonic_acoustic
);

  bef_pkg::cmd_t cmd;
  bef_pkg::sts_t sts;

  bef_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bef_dp #(
    .HARMONIC_MAX    (HARMONIC_MAX),
    .SNR_TABLE_DEPTH (SNR_TABLE_DEPTH)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_req_type           (in_req_type),
    .in_visual_valid       (in_visual_valid),
    .in_visual_snr         (in_visual_snr),
    .in_visual_freq        (in_visual_freq),
    .in_acoustic_valid     (in_acoustic_valid),
    .in_acoustic_snr       (in_acoustic_snr),
    .in_acoustic_freq      (in_acoustic_freq),
    .in_elevation_valid    (in_elevation_valid),
    .in_elevation          (in_elevation),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_probability       (out_probability),
    .out_matched           (out_matched),
    .out_harmonic_visual   (out_harmonic_visual),
    .out_harmonic_acoustic (out_harmonic_acoustic)
  );

endmodule
